### hw/rtl/icx_pkg.sv
// ----------------------------------------------------------------------------
// icx_pkg: INVITE client transaction shared definitions
// Widths, event and phase codes, register indexes and the records that pass
// between the control registers, the transaction core and the top level.
// ----------------------------------------------------------------------------
package icx_pkg;

   localparam int TICK_WIDTH   = 16;
   localparam int GIVEUP_SHIFT = 6;                       // timer B = 64 * T1
   localparam int LONG_WIDTH   = TICK_WIDTH + GIVEUP_SHIFT;
   localparam int CFG_WIDTH    = 16;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int MODE_WIDTH   = 2;
   localparam int CODE_WIDTH   = 10;
   localparam int PHASE_WIDTH  = 2;

   typedef logic [TICK_WIDTH-1:0]  tick_type;
   typedef logic [LONG_WIDTH-1:0]  long_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_type;
   typedef logic [CODE_WIDTH-1:0]  code_type;
   typedef logic [PHASE_WIDTH-1:0] phase_type;

   localparam cfg_type T1_RESET     = 16'd500;
   localparam cfg_type LINGER_RESET = 16'd32000;

   localparam code_type PROV_LO    = 10'd100;
   localparam code_type PROV_HI    = 10'd199;
   localparam code_type SUCCESS_LO = 10'd200;
   localparam code_type SUCCESS_HI = 10'd299;
   localparam code_type FAIL_LO    = 10'd300;
   localparam code_type FAIL_HI    = 10'd699;

   localparam phase_type PH_IDLE       = 2'd0;
   localparam phase_type PH_CALLING    = 2'd1;
   localparam phase_type PH_PROCEEDING = 2'd2;
   localparam phase_type PH_COMPLETED  = 2'd3;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_SEND     = 2'd0,
      MODE_RESPONSE = 2'd1,
      MODE_TICK     = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_T1     = 1'b0,
      CSR_LINGER = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE       = 4'b0001,
      ST_CALLING    = 4'b0010,
      ST_PROCEEDING = 4'b0100,
      ST_COMPLETED  = 4'b1000
   } state_type;

   typedef struct packed {
      mode_type mode;
      code_type status_code;
   } event_type;

   typedef struct packed {
      logic      tx_request;
      logic      tx_ack;
      logic      pass_response;
      logic      report_timeout;
      logic      finished;
      logic      ignored;
      phase_type phase;
   } result_type;

   typedef struct packed {
      tick_type t1;
      tick_type linger;
   } timing_type;

   function automatic phase_type phase_code(state_type st);
      phase_type p;
      case (st)
         ST_IDLE:       p = PH_IDLE;
         ST_CALLING:    p = PH_CALLING;
         ST_PROCEEDING: p = PH_PROCEEDING;
         ST_COMPLETED:  p = PH_COMPLETED;
         default:       p = PH_IDLE;
      endcase
      return p;
   endfunction

endpackage

### hw/rtl/icx_req_if.sv
// ----------------------------------------------------------------------------
// icx_req_if: event request channel
// Valid/ready channel carrying one transaction event.
// ----------------------------------------------------------------------------
interface icx_req_if import icx_pkg::*; ();
   logic     valid;
   logic     ready;
   logic [MODE_WIDTH-1:0] mode;
   code_type status_code;

   modport source (output valid, mode, status_code, input ready);
   modport sink   (input valid, mode, status_code, output ready);
endinterface

### hw/rtl/icx_rsp_if.sv
// ----------------------------------------------------------------------------
// icx_rsp_if: result channel
// Valid/ready channel carrying the action flags and phase for one event.
// ----------------------------------------------------------------------------
interface icx_rsp_if import icx_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      tx_request;
   logic      tx_ack;
   logic      pass_response;
   logic      report_timeout;
   logic      finished;
   logic      ignored;
   phase_type phase;

   modport source (output valid, tx_request, tx_ack, pass_response,
                   report_timeout, finished, ignored, phase, input ready);
   modport sink   (input valid, tx_request, tx_ack, pass_response,
                   report_timeout, finished, ignored, phase, output ready);
endinterface

### hw/rtl/icx_csr_if.sv
// ----------------------------------------------------------------------------
// icx_csr_if: register write channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface icx_csr_if import icx_pkg::*; ();
   logic    valid;
   logic    ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   cfg_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/icx_csr.sv
// ----------------------------------------------------------------------------
// icx_csr: timing registers
// Holds T1 and the timer D length, taken in their low tick-width bits.
// ----------------------------------------------------------------------------
module icx_csr import icx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] wr_index,
   input  cfg_type    wr_data,
   output timing_type timing
);

   tick_type t1_ff, t1_in;
   tick_type linger_ff, linger_in;

   always_comb begin
      t1_in     = t1_ff;
      linger_in = linger_ff;
      if (wr_en) begin
         case (csr_idx_type'(wr_index))
            CSR_T1:     t1_in     = tick_type'(wr_data);
            CSR_LINGER: linger_in = tick_type'(wr_data);
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff     <= tick_type'(T1_RESET);
         linger_ff <= tick_type'(LINGER_RESET);
      end else begin
         t1_ff     <= t1_in;
         linger_ff <= linger_in;
      end
   end

   assign timing = '{t1: t1_ff, linger: linger_ff};

endmodule

### hw/rtl/icx_core.sv
// ----------------------------------------------------------------------------
// icx_core: transaction phase and timers
// Phase register, timers A, B and D, and the per-event next-state logic.
// ----------------------------------------------------------------------------
module icx_core import icx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       ev_en,
   input  event_type  ev,
   input  timing_type timing,
   output result_type result
);

   localparam long_type LONG_ONES = '1;

   state_type state_ff, state_in;
   long_type  retry_interval_ff, retry_interval_in;
   long_type  retry_left_ff, retry_left_in;
   logic      retry_on_ff, retry_on_in;
   long_type  giveup_left_ff, giveup_left_in;
   logic      giveup_on_ff, giveup_on_in;
   tick_type  linger_left_ff, linger_left_in;
   logic      linger_on_ff, linger_on_in;

   logic     a_fire, b_fire, d_fire;
   long_type retry_dec, giveup_dec, retry_next;
   tick_type linger_dec;

   // a countdown at one or zero expires on the tick and parks at zero
   always_comb begin
      a_fire     = retry_on_ff  && (retry_left_ff  <= long_type'(1));
      b_fire     = giveup_on_ff && (giveup_left_ff <= long_type'(1));
      d_fire     = linger_on_ff && (linger_left_ff <= tick_type'(1));
      retry_dec  = (retry_left_ff  <= long_type'(1)) ? '0 : retry_left_ff  - long_type'(1);
      giveup_dec = (giveup_left_ff <= long_type'(1)) ? '0 : giveup_left_ff - long_type'(1);
      linger_dec = (linger_left_ff <= tick_type'(1)) ? '0 : linger_left_ff - tick_type'(1);
      // doubling saturates
      retry_next = retry_interval_ff[LONG_WIDTH-1] ? LONG_ONES
                                                   : {retry_interval_ff[LONG_WIDTH-2:0], 1'b0};
   end

   always_comb begin
      logic clear;
      clear = 1'b0;
      state_in          = state_ff;
      retry_interval_in = retry_interval_ff;
      retry_left_in     = retry_left_ff;
      retry_on_in       = retry_on_ff;
      giveup_left_in    = giveup_left_ff;
      giveup_on_in      = giveup_on_ff;
      linger_left_in    = linger_left_ff;
      linger_on_in      = linger_on_ff;
      result            = '0;

      case (ev.mode)
         MODE_SEND: begin
            if (state_ff == ST_IDLE) begin
               state_in             = ST_CALLING;
               result.tx_request    = 1'b1;
               retry_interval_in    = long_type'(timing.t1);
               retry_left_in        = long_type'(timing.t1);
               retry_on_in          = 1'b1;
               giveup_left_in       = long_type'(timing.t1) << GIVEUP_SHIFT;
               giveup_on_in         = 1'b1;
            end else begin
               result.ignored = 1'b1;
            end
         end
         MODE_RESPONSE: begin
            if (ev.status_code inside {[PROV_LO:PROV_HI]}) begin
               if (state_ff == ST_CALLING) begin
                  state_in             = ST_PROCEEDING;
                  clear                = 1'b1;
                  result.pass_response = 1'b1;
               end else if (state_ff == ST_PROCEEDING) begin
                  result.pass_response = 1'b1;
               end else begin
                  result.ignored = 1'b1;
               end
            end else if (ev.status_code inside {[SUCCESS_LO:SUCCESS_HI]}) begin
               if (state_ff == ST_CALLING || state_ff == ST_PROCEEDING) begin
                  state_in             = ST_IDLE;
                  clear                = 1'b1;
                  result.pass_response = 1'b1;
                  result.finished      = 1'b1;
               end else begin
                  result.ignored = 1'b1;
               end
            end else if (ev.status_code inside {[FAIL_LO:FAIL_HI]}) begin
               if (state_ff == ST_CALLING || state_ff == ST_PROCEEDING) begin
                  state_in             = ST_COMPLETED;
                  clear                = 1'b1;
                  result.tx_ack        = 1'b1;
                  result.pass_response = 1'b1;
               end else if (state_ff == ST_COMPLETED) begin
                  result.tx_ack = 1'b1;
               end else begin
                  result.ignored = 1'b1;
               end
            end else begin
               result.ignored = 1'b1;
            end
         end
         MODE_TICK: begin
            if (!retry_on_ff && !giveup_on_ff && !linger_on_ff) begin
               result.ignored = 1'b1;
            end else begin
               if (retry_on_ff)  retry_left_in  = retry_dec;
               if (giveup_on_ff) giveup_left_in = giveup_dec;
               if (linger_on_ff) linger_left_in = linger_dec;
               // timeout wins over a retransmit on the same tick
               if (b_fire) begin
                  state_in              = ST_IDLE;
                  clear                 = 1'b1;
                  result.report_timeout = 1'b1;
                  result.finished       = 1'b1;
               end else if (d_fire) begin
                  state_in        = ST_IDLE;
                  clear           = 1'b1;
                  result.finished = 1'b1;
               end else if (a_fire) begin
                  retry_interval_in   = retry_next;
                  retry_left_in       = retry_next;
                  result.tx_request   = 1'b1;
               end
            end
         end
         default: result.ignored = 1'b1;
      endcase

      if (clear) begin
         retry_interval_in = '0;
         retry_left_in     = '0;
         retry_on_in       = 1'b0;
         giveup_left_in    = '0;
         giveup_on_in      = 1'b0;
         linger_left_in    = '0;
         linger_on_in      = 1'b0;
      end
      // a failure response arms timer D after the clear
      if (ev.mode == MODE_RESPONSE && state_ff != ST_COMPLETED
          && state_in == ST_COMPLETED) begin
         linger_left_in = timing.linger;
         linger_on_in   = 1'b1;
      end

      result.phase = phase_code(state_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         retry_interval_ff <= '0;
         retry_left_ff     <= '0;
         retry_on_ff       <= 1'b0;
         giveup_left_ff    <= '0;
         giveup_on_ff      <= 1'b0;
         linger_left_ff    <= '0;
         linger_on_ff      <= 1'b0;
      end else if (ev_en) begin
         state_ff          <= state_in;
         retry_interval_ff <= retry_interval_in;
         retry_left_ff     <= retry_left_in;
         retry_on_ff       <= retry_on_in;
         giveup_left_ff    <= giveup_left_in;
         giveup_on_ff      <= giveup_on_in;
         linger_left_ff    <= linger_left_in;
         linger_on_ff      <= linger_on_in;
      end
   end

endmodule

### hw/rtl/invite_client_transaction_unit.sv
// ----------------------------------------------------------------------------
// invite_client_transaction_unit: INVITE client transaction
// Takes send, response and tick events and gives one result of action flags
// and the new phase for each.
// ----------------------------------------------------------------------------
// The unit accepts one event request per clock and delivers its result in the
// next cycle from the result register; a request is still taken while that
// register holds a result, as long as the result side takes it in the same
// cycle. Throughput is set by the loop through the phase and timer registers,
// which are updated in the cycle an event is accepted. Register writes are
// taken at any time and apply to the next send or failure response.
// ----------------------------------------------------------------------------
module invite_client_transaction_unit import icx_pkg::*; (
   input logic        clock,
   input logic        reset,
   icx_req_if.sink    req_if,
   icx_rsp_if.source  rsp_if,
   icx_csr_if.sink    csr_if
);

   timing_type timing;
   event_type  ev;
   result_type result;
   logic       accept;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign ev = '{mode: mode_type'(req_if.mode), status_code: req_if.status_code};

   icx_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .timing   (timing)
   );

   icx_core u_core (
      .clock  (clock),
      .reset  (reset),
      .ev_en  (accept),
      .ev     (ev),
      .timing (timing),
      .result (result)
   );

   assign out_valid_in = accept || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.tx_request     = out_ff.tx_request;
   assign rsp_if.tx_ack         = out_ff.tx_ack;
   assign rsp_if.pass_response  = out_ff.pass_response;
   assign rsp_if.report_timeout = out_ff.report_timeout;
   assign rsp_if.finished       = out_ff.finished;
   assign rsp_if.ignored        = out_ff.ignored;
   assign rsp_if.phase          = out_ff.phase;

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.finished |-> rsp_if.phase == PH_IDLE)
      else $error("finished result with a phase other than idle");

   a_ignored_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ignored |-> !(rsp_if.tx_request || rsp_if.tx_ack
         || rsp_if.pass_response || rsp_if.report_timeout || rsp_if.finished))
      else $error("ignored event raised an action");

   a_timeout_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.report_timeout |-> rsp_if.finished && !rsp_if.tx_request)
      else $error("timeout without termination");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted request gave no result");

endmodule
